### hdl/arw_pkg.sv
// ----------------------------------------------------------------------------
// Audio ring writer package
// Shared types, constants and register codes for the audio ring writer with
// drift-driven sample drop.
// ----------------------------------------------------------------------------
package arw_pkg;

  localparam int BufSlots = 1536;
  localparam int PtrW     = $clog2(BufSlots + 1);
  localparam int SlotW    = 11;
  localparam int CntW     = 20;
  localparam int TimeW    = 16;
  localparam int SampW    = 16;
  localparam int CfgDataW = 20;
  localparam int CfgIdxW  = 2;

  localparam logic [PtrW-1:0] PtrFull = PtrW'(BufSlots);
  localparam logic [PtrW-1:0] PtrHalf = PtrW'(BufSlots / 2);

  localparam logic [1:0] OP_HEADER  = 2'd0;
  localparam logic [1:0] OP_SAMPLE  = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_DRIFT_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DROP_INTERVAL   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DISCARD_PACKETS = 2'd2;

  localparam logic signed [15:0] RstDriftThreshold = 16'sd7000;
  localparam logic [CntW-1:0]    RstDropInterval   = 20'd25000;
  localparam logic [15:0]        RstDiscardPackets = 16'd500;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [TimeW-1:0] arrival_time;
    logic [TimeW-1:0] half_time;
    logic [SampW-1:0] sample_value;
  } arw_in_t;

  typedef struct packed {
    logic             write_valid;
    logic [SlotW-1:0] write_slot;
    logic [SampW-1:0] write_sample;
    logic             playback_start;
    logic             playback_pause;
    logic             sample_dropped;
  } arw_out_t;

  typedef struct packed {
    logic signed [15:0] drift_threshold;
    logic [CntW-1:0]    drop_interval;
    logic [15:0]        discard_packets;
  } arw_cfg_t;

  typedef struct packed {
    logic [PtrW-1:0]  write_pointer;
    logic [CntW-1:0]  kept_sample_counter;
    logic             drop_armed;
    logic             playing;
    logic [TimeW-1:0] packet_time;
    logic [15:0]      discarded_count;
    logic             discard_current;
  } arw_state_t;

endpackage

### hdl/arw_step.sv
// ----------------------------------------------------------------------------
// Audio ring writer step logic
// Next-state and result logic for one beat: header bookkeeping, ring slot
// writes with drift-driven drop, playback start and timeout pause.
// ----------------------------------------------------------------------------
module arw_step import arw_pkg::*; (
  input  arw_state_t state_i,
  input  arw_cfg_t   cfg_i,
  input  arw_in_t    item_i,
  output arw_state_t state_o,
  output arw_out_t   result_o
);

  logic [PtrW-1:0]    ptr_base;
  logic [PtrW-1:0]    ptr_inc;
  logic [CntW-1:0]    cnt_inc;
  logic signed [15:0] gap;
  logic               armed_base;

  always_comb begin
    gap        = signed'(state_i.packet_time - item_i.half_time);
    ptr_base   = state_i.write_pointer;
    armed_base = state_i.drop_armed;
    if (state_i.write_pointer >= PtrFull) begin
      ptr_base   = '0;
      armed_base = (gap < cfg_i.drift_threshold);
    end
    ptr_inc = ptr_base + PtrW'(1);
    cnt_inc = state_i.kept_sample_counter + CntW'(1);
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    case (item_i.opcode)
      OP_HEADER: begin
        state_o.packet_time = item_i.arrival_time;
        if (state_i.discarded_count < cfg_i.discard_packets) begin
          state_o.discarded_count = state_i.discarded_count + 16'd1;
          state_o.discard_current = 1'b1;
        end else begin
          state_o.discard_current = 1'b0;
        end
      end
      OP_SAMPLE: begin
        if (!state_i.discard_current) begin
          result_o.write_valid   = 1'b1;
          result_o.write_slot    = SlotW'(ptr_base);
          result_o.write_sample  = item_i.sample_value;
          state_o.write_pointer       = ptr_inc;
          state_o.drop_armed          = armed_base;
          state_o.kept_sample_counter = cnt_inc;
          if (cnt_inc == cfg_i.drop_interval) begin
            state_o.kept_sample_counter = '0;
            if (armed_base) begin
              state_o.write_pointer   = ptr_base;
              state_o.drop_armed      = 1'b0;
              result_o.sample_dropped = 1'b1;
            end
          end
          if (state_o.write_pointer == PtrHalf && !state_i.playing) begin
            state_o.playing         = 1'b1;
            result_o.playback_start = 1'b1;
          end
        end
      end
      OP_TIMEOUT: begin
        if (state_i.playing) begin
          state_o.playing         = 1'b0;
          result_o.playback_pause = 1'b1;
        end
        state_o.write_pointer = '0;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

### hdl/audio_ring_writer_drift_drop_top.sv
// ----------------------------------------------------------------------------
// Audio ring writer with drift drop, top level
// Takes headers, samples and timeouts, writes kept samples into the playback
// ring, drops at most one sample per ring pass at a drop-interval end when
// the stream runs ahead, and signals playback start and pause.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_stall_o  arw_in_t
//   out      output     out_valid_o / out_stall_i arw_out_t
//   cfg      input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// Each beat yields one result beat in the cycle after it is accepted. A new
// beat is taken every cycle unless stalled; the state update is the only loop.
// The result register frees as its beat is taken, so a stalled output blocks
// input only while a result is pending.
// Reset restores the register defaults and clears the state and output valid.
// ----------------------------------------------------------------------------
module audio_ring_writer_drift_drop_top import arw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  arw_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output arw_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  arw_cfg_t   cfg_q;
  arw_state_t state_q, state_d;
  arw_out_t   result_d, out_q;
  logic       out_valid_q;
  logic       in_accept;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  arw_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (in_data_i),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drift_threshold <= RstDriftThreshold;
      cfg_q.drop_interval   <= RstDropInterval;
      cfg_q.discard_packets <= RstDiscardPackets;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DRIFT_THRESHOLD: cfg_q.drift_threshold <= signed'(cfg_data_i[15:0]);
        REG_DROP_INTERVAL:   cfg_q.drop_interval   <= cfg_data_i;
        REG_DISCARD_PACKETS: cfg_q.discard_packets <= cfg_data_i[15:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= result_d;
    end
  end

  a_drop_needs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.sample_dropped |-> out_data_o.write_valid)
    else $error("sample drop reported without a ring write");

  a_start_pause_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.playback_start && out_data_o.playback_pause))
    else $error("playback start and pause in the same beat");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.write_pointer <= PtrFull)
    else $error("write pointer beyond the ring");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("accepted beat produced no result");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio ring writer testbench
// Drives headers, samples, timeouts and unknown opcodes through the ring
// writer with random sender gaps and receiver stalls. A short table covers
// reset defaults and field extremes. Short packet streams and random item
// mixes then run under several register settings, with timeouts rewinding
// the write slot. Every result beat is checked against the table's expected
// value or an in-bench model of the write pointer, drop and playback logic.
// ----------------------------------------------------------------------------
module tb_top;
  import arw_pkg::*;

  localparam logic [1:0]         OP_UNKNOWN = 2'd3;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
  localparam arw_out_t           NoResult   = '0;
  localparam int                 CycleLimit = 400000;

  typedef struct {
    bit                  is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    arw_in_t             beat;
    bit                  typed;
    arw_out_t            want;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  arw_in_t             in_data;
  logic                out_valid;
  logic                out_stall;
  arw_out_t            out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  audio_ring_writer_drift_drop_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Model state and register copies.
  logic signed [15:0] thr_reg;
  logic [CntW-1:0]    interval_reg;
  logic [15:0]        discard_reg;
  int unsigned        wr_ptr;
  logic [CntW-1:0]    kept_cnt;
  bit                 drop_armed;
  bit                 playing;
  logic [TimeW-1:0]   pkt_time;
  logic [15:0]        discard_cnt;
  bit                 discard_now;

  arw_out_t ring_update_q[$];
  dir_row_t directed_q[$];

  int cycles;
  int errors;
  int burst_left;
  int beats_in;
  int reg_writes;
  int results_checked;
  int samples_written;
  int drops_seen;
  int starts_seen;
  int pauses_seen;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles with %0d results pending", cycles,
               ring_update_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic arw_out_t predict_ring_update(input arw_in_t b);
    arw_out_t           r;
    logic signed [15:0] gap;
    r = '0;
    case (b.opcode)
      OP_HEADER: begin
        pkt_time = b.arrival_time;
        if (discard_cnt < discard_reg) begin
          discard_cnt = discard_cnt + 16'd1;
          discard_now = 1'b1;
        end else begin
          discard_now = 1'b0;
        end
      end
      OP_SAMPLE: begin
        if (!discard_now) begin
          if (wr_ptr >= BufSlots) begin
            gap = pkt_time - b.half_time;
            wr_ptr = 0;
            drop_armed = gap < thr_reg;
          end
          r.write_valid  = 1'b1;
          r.write_slot   = SlotW'(wr_ptr);
          r.write_sample = b.sample_value;
          wr_ptr++;
          kept_cnt = kept_cnt + 1'b1;
          if (kept_cnt == interval_reg) begin
            kept_cnt = '0;
            if (drop_armed) begin
              wr_ptr--;
              drop_armed = 1'b0;
              r.sample_dropped = 1'b1;
            end
          end
          if (wr_ptr == BufSlots / 2 && !playing) begin
            playing = 1'b1;
            r.playback_start = 1'b1;
          end
        end
      end
      OP_TIMEOUT: begin
        if (playing) begin
          playing = 1'b0;
          r.playback_pause = 1'b1;
        end
        wr_ptr = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic arw_in_t make_beat(input logic [1:0] op);
    arw_in_t b;
    b.opcode       = op;
    b.arrival_time = TimeW'($urandom);
    b.half_time    = TimeW'($urandom);
    b.sample_value = SampW'($urandom);
    return b;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    arw_out_t got;
    arw_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = out_data;
      if (ring_update_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending: %h", got));
      end else begin
        want = ring_update_q.pop_front();
        results_checked++;
        samples_written += want.write_valid;
        drops_seen      += want.sample_dropped;
        starts_seen     += want.playback_start;
        pauses_seen     += want.playback_pause;
        if (got.write_valid !== want.write_valid)
          report_mismatch($sformatf("write_valid %0b, want %0b",
                                    got.write_valid, want.write_valid));
        if (got.write_slot !== want.write_slot)
          report_mismatch($sformatf("write_slot %0d, want %0d",
                                    got.write_slot, want.write_slot));
        if (got.write_sample !== want.write_sample)
          report_mismatch($sformatf("write_sample %h, want %h",
                                    got.write_sample, want.write_sample));
        if (got.playback_start !== want.playback_start)
          report_mismatch($sformatf("playback_start %0b, want %0b",
                                    got.playback_start, want.playback_start));
        if (got.playback_pause !== want.playback_pause)
          report_mismatch($sformatf("playback_pause %0b, want %0b",
                                    got.playback_pause, want.playback_pause));
        if (got.sample_dropped !== want.sample_dropped)
          report_mismatch($sformatf("sample_dropped %0b, want %0b",
                                    got.sample_dropped, want.sample_dropped));
      end
    end
  end

  // The receiver switches between free flow, light, heavy and toggling stalls.
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(5, 80);
      end
      left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 4) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  task automatic send_beat(input arw_in_t b, input bit typed, input arw_out_t want);
    arw_out_t pred;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 12);
      if (in_valid) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    pred = predict_ring_update(b);
    ring_update_q.push_back(typed ? want : pred);
    beats_in++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] data);
    if (in_valid) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    while (ring_update_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DRIFT_THRESHOLD: thr_reg      = data[15:0];
      REG_DROP_INTERVAL:   interval_reg = data;
      REG_DISCARD_PACKETS: discard_reg  = data[15:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic configure(input logic [15:0] thr, input logic [CntW-1:0] interval,
                           input logic [15:0] discard);
    write_reg(REG_DRIFT_THRESHOLD, {4'($urandom), thr});
    write_reg(REG_DROP_INTERVAL, interval);
    write_reg(REG_DISCARD_PACKETS, {4'($urandom), discard});
  endtask

  task automatic add_beat(input logic [1:0] op, input logic [15:0] arrival,
                          input logic [15:0] half, input logic [15:0] sample,
                          input bit typed, input arw_out_t want);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.idx    = '0;
    row.data   = '0;
    row.beat   = '{op, arrival, half, sample};
    row.typed  = typed;
    row.want   = want;
    directed_q.push_back(row);
  endtask

  task automatic add_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    row.beat   = '0;
    row.typed  = 1'b0;
    row.want   = '0;
    directed_q.push_back(row);
  endtask

  // Packets of 1 to 48 samples behind a header, with rare timeouts and noise.
  task automatic run_stream(input int n_samples);
    int sent;
    int pkt_len;
    sent = 0;
    while (sent < n_samples) begin
      send_beat(make_beat(OP_HEADER), 1'b0, NoResult);
      pkt_len = $urandom_range(1, 48);
      repeat (pkt_len) send_beat(make_beat(OP_SAMPLE), 1'b0, NoResult);
      sent += pkt_len;
      if ($urandom_range(0, 399) == 0)
        send_beat(make_beat(OP_TIMEOUT), 1'b0, NoResult);
      else if ($urandom_range(0, 199) == 0)
        send_beat(make_beat(OP_UNKNOWN), 1'b0, NoResult);
    end
    send_beat(make_beat(OP_TIMEOUT), 1'b0, NoResult);
  endtask

  task automatic run_noise(input int n_items);
    int         pick;
    logic [1:0] op;
    repeat (n_items) begin
      pick = $urandom_range(0, 19);
      op = (pick < 10) ? OP_SAMPLE : (pick < 15) ? OP_HEADER :
           (pick < 18) ? OP_TIMEOUT : OP_UNKNOWN;
      send_beat(make_beat(op), 1'b0, NoResult);
    end
  endtask

  initial begin
    cycles          = 0;
    errors          = 0;
    burst_left      = 0;
    beats_in        = 0;
    reg_writes      = 0;
    results_checked = 0;
    samples_written = 0;
    drops_seen      = 0;
    starts_seen     = 0;
    pauses_seen     = 0;
    thr_reg         = RstDriftThreshold;
    interval_reg    = RstDropInterval;
    discard_reg     = RstDiscardPackets;
    wr_ptr          = 0;
    kept_cnt        = '0;
    drop_armed      = 1'b0;
    playing         = 1'b0;
    pkt_time        = '0;
    discard_cnt     = '0;
    discard_now     = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;

    // Reset defaults: samples before any header are kept, headers discard.
    add_beat(OP_SAMPLE, 16'h0000, 16'h0000, 16'hFFFF, 1'b1,
             '{1'b1, 11'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0});
    add_beat(OP_SAMPLE, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1,
             '{1'b1, 11'd1, 16'h0000, 1'b0, 1'b0, 1'b0});
    add_beat(OP_TIMEOUT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, NoResult);
    add_beat(OP_UNKNOWN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, NoResult);
    add_beat(OP_SAMPLE, 16'h0000, 16'h0000, 16'h8000, 1'b1,
             '{1'b1, 11'd0, 16'h8000, 1'b0, 1'b0, 1'b0});
    add_beat(OP_HEADER, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, NoResult);
    add_beat(OP_SAMPLE, 16'h0000, 16'h0000, 16'h1234, 1'b1, NoResult);
    add_beat(OP_HEADER, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, NoResult);
    add_beat(OP_SAMPLE, 16'h0000, 16'hFFFF, 16'h4321, 1'b1, NoResult);
    // Extreme settings: lowest threshold, widest interval, no discarding.
    add_cfg(REG_DRIFT_THRESHOLD, 20'hF8000);
    add_cfg(REG_DROP_INTERVAL, 20'hFFFFF);
    add_cfg(REG_DISCARD_PACKETS, 20'hF0000);
    add_beat(OP_HEADER, 16'h8000, 16'h7FFF, 16'h0000, 1'b1, NoResult);
    add_beat(OP_SAMPLE, 16'h0000, 16'h7FFF, 16'h7FFF, 1'b1,
             '{1'b1, 11'd1, 16'h7FFF, 1'b0, 1'b0, 1'b0});
    add_beat(OP_SAMPLE, 16'h1234, 16'h8000, 16'h5555, 1'b0, NoResult);
    add_beat(OP_UNKNOWN, 16'h0000, 16'h0000, 16'h0000, 1'b1, NoResult);
    add_beat(OP_TIMEOUT, 16'h0000, 16'h0000, 16'h0000, 1'b1, NoResult);
    add_beat(OP_SAMPLE, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, NoResult);
    add_cfg(REG_DRIFT_THRESHOLD, 20'h07FFF);
    add_beat(OP_HEADER, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, NoResult);
    add_beat(OP_SAMPLE, 16'h0F0F, 16'hF0F0, 16'h00FF, 1'b0, NoResult);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_q[i]) begin
      if (directed_q[i].is_cfg) begin
        write_reg(directed_q[i].idx, directed_q[i].data);
      end else begin
        send_beat(directed_q[i].beat, directed_q[i].typed, directed_q[i].want);
      end
    end

    configure(16'($urandom), kept_cnt + 20'($urandom_range(1, 30)),
              discard_cnt + 16'($urandom_range(0, 3)));
    run_noise(40);
    configure(16'h7FFF, kept_cnt + 20'($urandom_range(50, 400)), discard_cnt + 16'd2);
    run_stream(100);
    write_reg(REG_UNUSED, 20'($urandom));
    configure(16'($urandom), 20'd0, 16'hFFFF);
    run_noise(40);
    configure(16'($urandom), kept_cnt + 20'($urandom_range(1, 100)), discard_cnt);
    run_stream(60);
    configure(16'($urandom), kept_cnt + 20'($urandom_range(1, 10)), discard_cnt + 16'd1);
    run_noise(40);
    configure(16'($urandom), kept_cnt + 20'($urandom_range(20, 300)),
              discard_cnt + 16'($urandom_range(0, 3)));
    run_stream(80);

    @(negedge clk);
    in_valid <= 1'b0;
    while (ring_update_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Sent %0d beats and %0d register writes; checked %0d results.",
             beats_in, reg_writes, results_checked);
    $display("Covered %0d ring writes, %0d drops, %0d playback starts, %0d pauses.",
             samples_written, drops_seen, starts_seen, pauses_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### audio_ring_writer_drift_drop_top.f
hdl/arw_pkg.sv
hdl/arw_step.sv
hdl/audio_ring_writer_drift_drop_top.sv
test/tb_top.sv
